// File: design/mm64_pkg.sv
// shared constants, codes and types of the murmur64a hash block
package mm64_pkg;

  localparam int unsigned DATA_W      = 64;
  localparam int unsigned LEN_W       = 32;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned HALF_W      = 32;
  localparam int unsigned SHIFT_K     = 47;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [DATA_W-1:0] MUL_K      = 64'hc6a4a7935bd1e995;
  localparam logic [DATA_W-1:0] SEED_RESET = 64'h0000_0000_41C6_4E6D;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_NONE = 2'd0;
  localparam kind_t KIND_FULL = 2'd1;
  localparam kind_t KIND_TAIL = 2'd2;

  typedef struct packed {
    logic [DATA_W-1:0] word;
    kind_t             kind;
    logic              first;
    logic              last;
    logic [LEN_W-1:0]  len;
  } mm64_op_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] a;
  } mm64_mreq_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] p;
  } mm64_mrsp_t;

endpackage

// File: design/mm64_front.sv
// input side: classifies items, masks tail bytes and queues them for the back end
module mm64_front #(
  parameter int unsigned QUEUE_DEPTH = mm64_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [mm64_pkg::DATA_W-1:0]  in_data_word,
  input  logic [mm64_pkg::CNT_W-1:0]   in_byte_count,
  input  logic                         in_first_item,
  input  logic                         in_last_item,
  input  logic [mm64_pkg::LEN_W-1:0]   in_total_length,
  output logic                         q_valid,
  output mm64_pkg::mm64_op_t           q_op,
  input  logic                         q_pop
);
  import mm64_pkg::*;

  localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  mm64_op_t          slot_r [QUEUE_DEPTH];
  logic [IW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [IW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [DATA_W-1:0] mask;
  mm64_op_t          op_in;
  logic              do_push;
  logic              do_pop;

  // byte enables from the count, then kind of work
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mask[b*8 +: 8] = {8{in_byte_count > CNT_W'(b)}};
    end
    op_in.first = in_first_item;
    op_in.last  = in_last_item;
    op_in.len   = in_total_length;
    if (in_byte_count == '0) begin
      op_in.kind = KIND_NONE;
      op_in.word = '0;
    end else if (in_byte_count[CNT_W-1]) begin
      op_in.kind = KIND_FULL;
      op_in.word = in_data_word;
    end else begin
      op_in.kind = KIND_TAIL;
      op_in.word = in_data_word & mask;
    end
  end

  assign in_full = (count_r == CW'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_op    = slot_r[rd_ptr_r];
  assign do_push = in_push && !in_full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == IW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == IW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= op_in;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

// File: design/mm64_mul.sv
// shared 64-bit multiply by the mixing constant, one 32x32 partial product a cycle
module mm64_mul (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mm64_pkg::mm64_mreq_t  mreq,
  output mm64_pkg::mm64_mrsp_t  mrsp
);
  import mm64_pkg::*;

  logic [DATA_W-1:0] a_r, a_nxt;
  logic [DATA_W-1:0] prod_r, prod_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [1:0]        step_r, step_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [HALF_W-1:0] mx;
  logic [HALF_W-1:0] my;
  logic [DATA_W-1:0] mp;

  // low 64 bits: al*kl + ((al*kh + ah*kl) << 32)
  assign mx = (step_r == 2'd2) ? a_r[DATA_W-1:HALF_W] : a_r[HALF_W-1:0];
  assign my = (step_r == 2'd1) ? MUL_K[DATA_W-1:HALF_W] : MUL_K[HALF_W-1:0];
  assign mp = DATA_W'(mx) * DATA_W'(my);

  always_comb begin
    a_nxt    = a_r;
    prod_nxt = prod_r;
    acc_nxt  = acc_r;
    step_nxt = step_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (mreq.start) begin
      a_nxt    = mreq.a;
      step_nxt = 2'd0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      step_nxt = step_r + 1'b1;
      case (step_r)
        2'd0: begin
          prod_nxt = mp;
        end
        2'd1: begin
          acc_nxt  = prod_r;
          prod_nxt = {{HALF_W{1'b0}}, mp[HALF_W-1:0]};
        end
        2'd2: begin
          acc_nxt[DATA_W-1:HALF_W] = acc_r[DATA_W-1:HALF_W] + prod_r[HALF_W-1:0];
          prod_nxt = {{HALF_W{1'b0}}, mp[HALF_W-1:0]};
        end
        default: begin
          acc_nxt[DATA_W-1:HALF_W] = acc_r[DATA_W-1:HALF_W] + prod_r[HALF_W-1:0];
          run_nxt  = 1'b0;
          done_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign mrsp.busy = run_r;
  assign mrsp.done = done_r;
  assign mrsp.p    = acc_r;

  a_done_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(run_r && step_r == 2'd3 && !mreq.start))
    else $error("multiply done without its last step");

endmodule

// File: design/mm64_back.sv
// execution side: sequences the hash recurrence over the shared multiplier
module mm64_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [mm64_pkg::DATA_W-1:0]  seed,
  input  logic                         q_valid,
  input  mm64_pkg::mm64_op_t           q_op,
  output logic                         q_pop,
  output mm64_pkg::mm64_mreq_t         mreq,
  input  mm64_pkg::mm64_mrsp_t         mrsp,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [mm64_pkg::DATA_W-1:0]  out_hash_value
);
  import mm64_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LEN  = 4'd1;
  localparam logic [3:0] S_WORD = 4'd2;
  localparam logic [3:0] S_K1   = 4'd3;
  localparam logic [3:0] S_K2   = 4'd4;
  localparam logic [3:0] S_FOLD = 4'd5;
  localparam logic [3:0] S_FIN  = 4'd6;
  localparam logic [3:0] S_F1   = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  function automatic logic [DATA_W-1:0] xsh(input logic [DATA_W-1:0] v);
    return v ^ (v >> SHIFT_K);
  endfunction

  logic [3:0]        state_r, state_nxt;
  mm64_op_t          op_r, op_nxt;
  logic [DATA_W-1:0] hash_r, hash_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_hash_r, out_hash_nxt;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    hash_nxt      = hash_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_hash_nxt  = out_hash_r;
    q_pop         = 1'b0;
    mreq.start    = 1'b0;
    mreq.a        = '0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          op_nxt = q_op;
          if (q_op.first) begin
            mreq.start = 1'b1;
            mreq.a     = {{(DATA_W-LEN_W){1'b0}}, q_op.len};
            state_nxt  = S_LEN;
          end else begin
            state_nxt = S_WORD;
          end
        end
      end
      S_LEN: begin
        if (mrsp.done) begin
          hash_nxt  = seed ^ mrsp.p;
          state_nxt = S_WORD;
        end
      end
      S_WORD: begin
        case (op_r.kind)
          KIND_FULL: begin
            mreq.start = 1'b1;
            mreq.a     = op_r.word;
            state_nxt  = S_K1;
          end
          KIND_TAIL: begin
            hash_nxt   = hash_r ^ op_r.word;
            mreq.start = 1'b1;
            mreq.a     = hash_r ^ op_r.word;
            state_nxt  = S_FOLD;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_K1: begin
        if (mrsp.done) begin
          mreq.start = 1'b1;
          mreq.a     = xsh(mrsp.p);
          state_nxt  = S_K2;
        end
      end
      S_K2: begin
        if (mrsp.done) begin
          hash_nxt   = hash_r ^ mrsp.p;
          mreq.start = 1'b1;
          mreq.a     = hash_r ^ mrsp.p;
          state_nxt  = S_FOLD;
        end
      end
      S_FOLD: begin
        if (mrsp.done) begin
          hash_nxt  = mrsp.p;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (op_r.last) begin
          mreq.start = 1'b1;
          mreq.a     = xsh(hash_r);
          state_nxt  = S_F1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_F1: begin
        if (mrsp.done) begin
          hash_nxt  = xsh(mrsp.p);
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_pop) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = hash_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hash_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hash_r      <= hash_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    out_hash_r <= out_hash_nxt;
  end

  assign out_empty      = !out_valid_r;
  assign out_hash_value = out_hash_r;

  a_no_start_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(mreq.start && mrsp.busy))
    else $error("multiply started while busy");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result loaded outside emit");

  a_idle_mul_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mrsp.busy)
    else $error("multiplier running while idle");

endmodule

// File: design/murmur64a_hash.sv
// top level of the streaming murmurhash64a block
//
//  channel  direction  handshake             payload
//  in_      in         in_push / in_full     data_word, byte_count, first_item,
//                                            last_item, total_length
//  out_     out        out_empty / out_pop   hash_value
//  cfg_     in         cfg_valid / cfg_ready seed
//
// a 64-bit multiply runs in 4 steps on the shared 32x32 multiplier (three partial products
// and a final add) before its hand-off; multiplies per item: first item +1, full word +3,
// tail word +1, last item +1, and a last item ends with an emit step
// reset is synchronous active low: queue empty, running hash zero, seed 0x41c64e6d
// the input queue keeps accepting, until it is full, while the back end works or a result waits unread
// the back end stalls in its emit step only while the result register is still full
module murmur64a_hash #(
  parameter int unsigned QUEUE_DEPTH = mm64_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [mm64_pkg::DATA_W-1:0]  in_data_word,
  input  logic [mm64_pkg::CNT_W-1:0]   in_byte_count,
  input  logic                         in_first_item,
  input  logic                         in_last_item,
  input  logic [mm64_pkg::LEN_W-1:0]   in_total_length,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [mm64_pkg::DATA_W-1:0]  out_hash_value,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mm64_pkg::DATA_W-1:0]  cfg_seed
);
  import mm64_pkg::*;

  logic [DATA_W-1:0] seed_r, seed_nxt;
  logic              q_valid;
  mm64_op_t          q_op;
  logic              q_pop;
  mm64_mreq_t        mreq;
  mm64_mrsp_t        mrsp;

  assign cfg_ready = 1'b1;
  assign seed_nxt  = (cfg_valid && cfg_ready) ? cfg_seed : seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  mm64_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_data_word    (in_data_word),
    .in_byte_count   (in_byte_count),
    .in_first_item   (in_first_item),
    .in_last_item    (in_last_item),
    .in_total_length (in_total_length),
    .q_valid         (q_valid),
    .q_op            (q_op),
    .q_pop           (q_pop)
  );

  mm64_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .mreq  (mreq),
    .mrsp  (mrsp)
  );

  mm64_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .seed           (seed_r),
    .q_valid        (q_valid),
    .q_op           (q_op),
    .q_pop          (q_pop),
    .mreq           (mreq),
    .mrsp           (mrsp),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_hash_value (out_hash_value)
  );

endmodule
